@@ rtl/pcfl_pkg.sv @@
// Package: shared types, codes and defaults for the per-core page free-list allocator.
`default_nettype none

package pcfl_pkg;

  // Default sizing
  localparam int NUM_CORES_DEF = 8;
  localparam int NUM_PAGES_DEF = 32768;

  // Fixed field widths
  localparam int PAGE_W = 15;
  localparam int CORE_W = 3;
  localparam int CFG_W  = 16;
  localparam int LINK_W = PAGE_W + 1;

  // Register reset values
  localparam logic [CFG_W-1:0] LOW_PAGE_RESET = 16'h0000;
  localparam logic [CFG_W-1:0] TOP_PAGE_RESET = 16'h8000;

  // Register indexes
  localparam logic [0:0] CFG_LOW_PAGE = 1'b0;
  localparam logic [0:0] CFG_TOP_PAGE = 1'b1;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FREED = 2'd1,
    ST_OOM   = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [CORE_W-1:0] core;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page_out;
    logic              stolen;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/pcfl_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pcfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/per_core_page_free_list_allocator.sv @@
// Top level: per-core LIFO page free lists with stealing, links held in one RAM.
// Free: result strobe in the cycle after accept; a new request can follow every cycle.
// Allocate: the registered read of the link RAM at the list head must return
//   before the head register can be updated in S_POP; busy is high in S_POP.
// Out of memory and bad free report the cycle after accept. Results cannot be stalled.
// Reset (synchronous, active low) empties all lists at once; link RAM is not cleared.
`default_nettype none

module per_core_page_free_list_allocator
  import pcfl_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF,
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             in_req,
  // result channel
  output logic                  out_valid,
  output rsp_t                  out_rsp,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  // Configuration registers
  logic [CFG_W-1:0] low_page_r;
  logic [CFG_W-1:0] top_page_r;

  // List heads
  logic [PAGE_W-1:0] head_page_r  [NUM_CORES];
  logic              head_valid_r [NUM_CORES];

  // Controller
  state_t state_r, state_nxt;
  logic [CW-1:0]     pop_core_r, pop_core_nxt;
  logic [PAGE_W-1:0] pop_page_r, pop_page_nxt;
  logic              pop_stolen_r, pop_stolen_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  // Head update
  logic              head_we;
  logic [CW-1:0]     head_idx;
  logic [PAGE_W-1:0] head_wpage;
  logic              head_wvalid;

  // Link RAM
  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [AW-1:0]     link_raddr;
  logic [LINK_W-1:0] link_rdata;

  // Request decode
  logic          accept;
  logic [CW-1:0] core_idx;
  logic          page_bad;
  logic          own_valid;
  logic          steal_found;
  logic [CW-1:0] steal_idx;

  // Core index modulo the core count (input is only 3 bits wide)
  always_comb begin
    core_idx = '0;
    for (int i = 0; i < (1 << CORE_W); i++) begin
      if (in_req.core == CORE_W'(i)) begin
        core_idx = CW'(i % NUM_CORES);
      end
    end
  end

  // Bounds check on freed page
  always_comb begin
    page_bad = ({1'b0, in_req.page} < low_page_r) ||
               ({1'b0, in_req.page} >= top_page_r) ||
               (32'(in_req.page) >= 32'(NUM_PAGES));
  end

  // Victim selection: own list first, else lowest-numbered other nonempty list
  always_comb begin
    own_valid   = head_valid_r[core_idx];
    steal_found = 1'b0;
    steal_idx   = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if ((CW'(i) != core_idx) && head_valid_r[i]) begin
        steal_found = 1'b1;
        steal_idx   = CW'(i);
      end
    end
  end

  assign accept = start && (state_r == S_IDLE);

  // Next state, RAM accesses, head updates and results
  always_comb begin
    state_nxt      = state_r;
    pop_core_nxt   = pop_core_r;
    pop_page_nxt   = pop_page_r;
    pop_stolen_nxt = pop_stolen_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    head_we        = 1'b0;
    head_idx       = core_idx;
    head_wpage     = in_req.page;
    head_wvalid    = 1'b1;
    link_we        = 1'b0;
    link_waddr     = AW'(in_req.page);
    link_wdata     = {head_valid_r[core_idx],
                      head_valid_r[core_idx] ? head_page_r[core_idx] : {PAGE_W{1'b0}}};
    link_raddr     = AW'(head_page_r[core_idx]);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rsp_nxt.page_out = '0;
          out_rsp_nxt.stolen   = 1'b0;
          if (in_req.mode == MODE_FREE) begin
            // push onto own list
            out_valid_nxt = 1'b1;
            if (page_bad) begin
              out_rsp_nxt.status = ST_BAD;
            end else begin
              out_rsp_nxt.status = ST_FREED;
              link_we            = 1'b1;
              head_we            = 1'b1;
            end
          end else if (own_valid) begin
            // pop own list: read link at head
            pop_core_nxt   = core_idx;
            pop_page_nxt   = head_page_r[core_idx];
            pop_stolen_nxt = 1'b0;
            state_nxt      = S_POP;
          end else if (steal_found) begin
            link_raddr     = AW'(head_page_r[steal_idx]);
            pop_core_nxt   = steal_idx;
            pop_page_nxt   = head_page_r[steal_idx];
            pop_stolen_nxt = 1'b1;
            state_nxt      = S_POP;
          end else begin
            out_valid_nxt      = 1'b1;
            out_rsp_nxt.status = ST_OOM;
          end
        end
      end
      S_POP: begin
        // link data arrives: advance the head, report the page
        head_we              = 1'b1;
        head_idx             = pop_core_r;
        head_wvalid          = link_rdata[LINK_W-1];
        head_wpage           = link_rdata[LINK_W-1] ? link_rdata[PAGE_W-1:0] : '0;
        out_valid_nxt        = 1'b1;
        out_rsp_nxt.status   = ST_ALLOC;
        out_rsp_nxt.page_out = pop_page_r;
        out_rsp_nxt.stolen   = pop_stolen_r;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pop_core_r   <= pop_core_nxt;
    pop_page_r   <= pop_page_nxt;
    pop_stolen_r <= pop_stolen_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  // List heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORES; i++) begin
        head_valid_r[i] <= 1'b0;
      end
    end else if (head_we) begin
      head_valid_r[head_idx] <= head_wvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_page_r[head_idx] <= head_wpage;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_page_r <= LOW_PAGE_RESET;
      top_page_r <= TOP_PAGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOW_PAGE: low_page_r <= cfg_wdata;
        CFG_TOP_PAGE: top_page_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared next-link memory
  pcfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign busy      = (state_r == S_POP);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

@@ rtl/pcfl_checker.sv @@
// Port-level checker for the page free-list allocator, bound to the top level.
`default_nettype none

module pcfl_checker
  import pcfl_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire req_t in_req,
  input wire logic out_valid,
  input wire rsp_t out_rsp
);

  // Busy only follows an accepted allocate
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_req.mode == MODE_ALLOC)))
    else $error("busy rose without an allocate request");

  // An allocate pop lasts a single cycle and ends in a successful result
  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid && (out_rsp.status == ST_ALLOC)))
    else $error("pop did not complete with an allocated result");

  // Every accepted request either reports next cycle or enters the pop
  a_req_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid != busy))
    else $error("accepted request neither answered nor popping");

  // A free answers at once with freed or bad address
  a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.mode == MODE_FREE)) |=>
      (out_valid && ((out_rsp.status == ST_FREED) || (out_rsp.status == ST_BAD))))
    else $error("free request gave wrong status");

  // Non-allocate results carry no page and no steal flag
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != ST_ALLOC)) |->
      ((out_rsp.page_out == '0) && !out_rsp.stolen))
    else $error("nonzero page or stolen on a non-allocate result");

endmodule

bind per_core_page_free_list_allocator pcfl_checker u_pcfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

`default_nettype wire

@@ tb/per_core_page_free_list_allocator_tb.sv @@
// Testbench for the per-core page free-list allocator: directed and random requests, scoreboard.
`default_nettype none

module per_core_page_free_list_allocator_tb;
  import pcfl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCORES      = NUM_CORES_DEF;
  localparam int NPAGES      = NUM_PAGES_DEF;
  localparam int STALL_LIMIT = 1000;

  // Shadow copy of the free lists; predicts one result per accepted request
  class alloc_scoreboard;
    logic [PAGE_W-1:0] head_pg [NCORES];
    bit                head_vld [NCORES];
    logic [LINK_W-1:0] next_link [NPAGES];
    logic [CFG_W-1:0]  low_bound;
    logic [CFG_W-1:0]  top_bound;
    rsp_t              pending_results [$];
    int                errors;

    function new();
      low_bound = LOW_PAGE_RESET;
      top_bound = TOP_PAGE_RESET;
      foreach (head_pg[i]) begin
        head_pg[i]  = '0;
        head_vld[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_LOW_PAGE) begin
        low_bound = val;
      end else begin
        top_bound = val;
      end
    endfunction

    // Pop the head of list c; bit 15 of the link says whether a next page exists
    function logic [PAGE_W-1:0] take_head(int c);
      logic [PAGE_W-1:0] pg;
      logic [LINK_W-1:0] nx;
      pg          = head_pg[c];
      nx          = next_link[pg];
      head_vld[c] = nx[LINK_W-1];
      head_pg[c]  = nx[LINK_W-1] ? nx[PAGE_W-1:0] : '0;
      return pg;
    endfunction

    function rsp_t note_request(req_t r);
      rsp_t e;
      int   c;
      e.status   = ST_OOM;
      e.page_out = '0;
      e.stolen   = 1'b0;
      c          = int'(r.core) % NCORES;
      if (r.mode == MODE_FREE) begin
        if ({1'b0, r.page} < low_bound || {1'b0, r.page} >= top_bound) begin
          e.status = ST_BAD;
        end else begin
          next_link[r.page] = head_vld[c] ? {1'b1, head_pg[c]} : '0;
          head_pg[c]        = r.page;
          head_vld[c]       = 1'b1;
          e.status          = ST_FREED;
        end
      end else if (head_vld[c]) begin
        e.page_out = take_head(c);
        e.status   = ST_ALLOC;
      end else begin
        // own list empty: steal from the lowest-numbered non-empty list
        for (int i = 0; i < NCORES; i++) begin
          if (e.status == ST_OOM && i != c && head_vld[i]) begin
            e.page_out = take_head(i);
            e.stolen   = 1'b1;
            e.status   = ST_ALLOC;
          end
        end
      end
      pending_results.push_back(e);
      return e;
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no request pending: status %s page %0d stolen %0d",
                   $realtime, got.status.name(), got.page_out, got.stolen);
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status || got.page_out !== e.page_out || got.stolen !== e.stolen) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: exp status %s page %0d stolen %0d, got status %s page %0d stolen %0d",
                   $realtime, e.status.name(), e.page_out, e.stolen,
                   got.status.name(), got.page_out, got.stolen);
      end
    endfunction
  endclass

  // Where the stimulus side believes each page is
  typedef enum logic [1:0] {
    PG_UNUSED,
    PG_LISTED,
    PG_HELD
  } page_use_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  req_t             in_req    = '0;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_addr  = CFG_LOW_PAGE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  alloc_scoreboard sb;
  page_use_t       page_use [NPAGES];
  int              held_pages [$];
  int              last_freed = 0;
  bit              have_freed = 1'b0;
  int              idle_cycles = 0;

  always #1 clk = ~clk;

  per_core_page_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  // Watchdog: cycles with neither a request nor a result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted; start stays high afterwards
  task automatic request(logic mode, int core, int page);
    req_t r;
    rsp_t e;
    r.mode = mode;
    r.core = core[CORE_W-1:0];
    r.page = page[PAGE_W-1:0];
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    e = sb.note_request(r);
    if (e.status == ST_FREED) begin
      page_use[r.page] = PG_LISTED;
      last_freed       = int'(r.page);
      have_freed       = 1'b1;
    end else if (e.status == ST_ALLOC && page_use[e.page_out] != PG_HELD) begin
      page_use[e.page_out] = PG_HELD;
      held_pages.push_back(int'(e.page_out));
    end
  endtask

  // Sender gap with junk on the request bus
  task automatic pause(int n);
    logic [31:0] junk;
    junk = $urandom;
    start  <= 1'b0;
    in_req <= junk[$bits(req_t)-1:0];
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every expected result is back
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LOW_PAGE;
    cfg_wdata <= lo;
    @(posedge clk);
    sb.write_reg(CFG_LOW_PAGE, lo);
    cfg_addr  <= CFG_TOP_PAGE;
    cfg_wdata <= hi;
    @(posedge clk);
    sb.write_reg(CFG_TOP_PAGE, hi);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed alloc/free traffic; noise is frees of arbitrary pages,
  // and in the corrupting phase also repeated frees of a page already listed
  task automatic run_random(int n, int idle_pct, int noise_pct, bit corrupt);
    int   lo, hi, p, idx, roll;
    logic m;
    bit   picked;
    for (int i = 0; i < n; i++) begin
      lo   = int'(sb.low_bound);
      hi   = (int'(sb.top_bound) > NPAGES) ? NPAGES : int'(sb.top_bound);
      roll = $urandom_range(0, 99);
      m    = MODE_ALLOC;
      p    = $urandom_range(0, NPAGES - 1);
      if (roll < noise_pct) begin
        if (corrupt && have_freed && $urandom_range(0, 1)) begin
          m = MODE_FREE;
          p = last_freed;
        end else if (corrupt || page_use[p] != PG_LISTED) begin
          m = MODE_FREE;
        end
      end else if ($urandom_range(0, 1)) begin
        picked = 1'b0;
        if (held_pages.size() != 0) begin
          idx = $urandom_range(0, held_pages.size() - 1);
          p   = held_pages[idx];
          if (page_use[p] != PG_HELD) begin
            held_pages.delete(idx);
          end else if (p >= lo && p < hi) begin
            held_pages.delete(idx);
            picked = 1'b1;
          end
        end
        for (int t = 0; t < 4 && !picked && lo < hi; t++) begin
          p      = $urandom_range(lo, hi - 1);
          picked = (page_use[p] == PG_UNUSED);
        end
        if (picked) m = MODE_FREE;
      end
      request(m, $urandom_range(0, NCORES - 1), p);
      if (idle_pct != 0 && (i % 64) < 40 && $urandom_range(0, 99) < idle_pct)
        pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    sb = new();
    foreach (page_use[i]) page_use[i] = PG_UNUSED;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset bounds: empty lists, extreme pages, own pop, steal
    request(MODE_ALLOC, 0, 0);
    request(MODE_FREE, 3, 0);
    request(MODE_FREE, 3, NPAGES - 1);
    request(MODE_ALLOC, 3, 0);
    request(MODE_ALLOC, 5, 0);
    request(MODE_ALLOC, 5, 0);
    settle();

    // Directed, narrow window: bound checks, cross-core double free, steal order
    configure(16'd100, 16'd200);
    request(MODE_FREE, 0, 99);
    request(MODE_FREE, 0, 200);
    request(MODE_FREE, 0, 100);
    request(MODE_FREE, 0, 199);
    pause(3);
    request(MODE_FREE, 4, 150);
    request(MODE_FREE, 7, 150);
    request(MODE_ALLOC, 2, 0);
    request(MODE_ALLOC, 6, 0);
    request(MODE_ALLOC, 6, 0);
    request(MODE_ALLOC, 7, 0);
    request(MODE_ALLOC, 1, 0);
    request(MODE_FREE, 7, NPAGES - 1);
    settle();

    // Empty window: every free is rejected
    configure(16'h0000, 16'h0000);
    request(MODE_FREE, 2, 0);
    settle();

    // Full page range
    configure(16'h0000, 16'h8000);
    run_random(560, 30, 8, 1'b0);
    settle();

    // Top bound beyond the page count, only the last 16 pages usable
    configure(16'h7FF0, 16'hFFFF);
    run_random(520, 20, 20, 1'b0);
    settle();

    // Low bound above top: lists drain, frees all rejected
    configure(16'hFFFF, 16'h0000);
    run_random(100, 25, 30, 1'b0);
    settle();

    // Back-to-back traffic with double frees that corrupt the lists
    configure(16'd5, 16'd1000);
    run_random(450, 0, 12, 1'b1);
    settle();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
